>>> rtl/pwsr_pkg.sv
// Package for the pulse width sensor reader.
// Holds the transaction payload types, phase codes, register indexes and constants.
// No dependencies.
package pwsr_pkg;

  localparam int unsigned HoldWidth    = 20;
  localparam int unsigned StartWidth   = 16;
  localparam int unsigned TimeoutWidth = 22;
  localparam int unsigned CfgDataWidth = 22;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned FrameBits    = 40;
  localparam int unsigned BitIdxWidth  = 6;
  localparam int unsigned DurWidth     = TimeoutWidth + 1;

  localparam logic [HoldWidth-1:0]    HoldReset    = 20'd500000;
  localparam logic [StartWidth-1:0]   StartReset   = 16'd20000;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 22'd3200000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgHoldHigh = 2'd0,
    CfgStartLow = 2'd1,
    CfgTimeout  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatTimeout  = 2'd1,
    StatChecksum = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    PhIdle     = 8'b0000_0001,
    PhHold     = 8'b0000_0010,
    PhStart    = 8'b0000_0100,
    PhWaitLow  = 8'b0000_1000,
    PhHsLow    = 8'b0001_0000,
    PhHsHigh   = 8'b0010_0000,
    PhDataLow  = 8'b0100_0000,
    PhDataHigh = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic pin_level;
    logic start_req;
  } in_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       result_valid;
    logic [7:0] humidity;
    logic [1:0] status;
  } out_t;

endpackage

>>> rtl/pulse_width_sensor_reader.sv
// Top level of the pulse width sensor reader: phase machine, pulse timing and frame check.
// Depends on pwsr_pkg.
//
// Usage: one input transaction is sent per microsecond tick, carrying the sampled
// data pin level and a start request. Each accepted transaction yields exactly one
// output transaction carrying the pin drive controls, the busy flag and, on the tick
// a reading ends, the humidity byte and a status (ok, handshake timeout, checksum).
// A start request is taken only while idle. The configuration port writes the hold
// time, the start pulse length and the wait timeout; the user must write it while idle,
// which the block does not enforce. A transaction's result appears in the output register
// on the cycle after acceptance. Throughput is one transaction per cycle while the
// receiver takes each result, set by the single state update before the output register.
// When the receiver stalls, the finished result waits in the output register and
// input ready drops, so the reading freezes and no pin sample is lost.
// Reset puts the reader idle with counters and frame cleared, restores the register
// defaults and empties the output register.
module pulse_width_sensor_reader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pwsr_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pwsr_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [pwsr_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [pwsr_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import pwsr_pkg::*;

  logic [HoldWidth-1:0]    hold_q;
  logic [StartWidth-1:0]   start_q;
  logic [TimeoutWidth-1:0] timeout_q;

  phase_e                  phase_q, phase_d;
  logic [TimeoutWidth-1:0] tick_q, tick_d;
  logic signed [DurWidth-1:0] low_q, low_d;
  logic [BitIdxWidth-1:0]  bidx_q, bidx_d;
  logic [FrameBits-1:0]    frame_q, frame_d;

  logic                    out_valid_q;
  out_t                    out_q, res;

  logic                    in_fire;
  logic [TimeoutWidth-1:0] tick_inc;
  logic                    wait_lvl;
  logic                    changed;
  logic                    tmo;
  logic signed [DurWidth-1:0] wait_dur;
  logic                    new_bit;
  logic [FrameBits-1:0]    frame_new;
  logic [BitIdxWidth-1:0]  bidx_new;
  logic [7:0]              csum;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= HoldReset;
      start_q   <= StartReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHoldHigh: hold_q    <= cfg_data_i[HoldWidth-1:0];
        CfgStartLow: start_q   <= cfg_data_i[StartWidth-1:0];
        CfgTimeout:  timeout_q <= cfg_data_i[TimeoutWidth-1:0];
        default: ;
      endcase
    end
  end

  assign tick_inc = tick_q + TimeoutWidth'(1);
  assign wait_lvl = (phase_q == PhWaitLow) || (phase_q == PhHsHigh) ||
                    (phase_q == PhDataHigh);
  assign changed  = in_data_i.pin_level != wait_lvl;
  assign tmo      = !changed && (tick_q >= timeout_q);
  assign wait_dur = tmo ? '1 : $signed({1'b0, tick_q});
  assign new_bit  = wait_dur > low_q;
  assign frame_new = {frame_q[FrameBits-2:0], new_bit};
  assign bidx_new = bidx_q + BitIdxWidth'(1);
  assign csum     = frame_new[39:32] + frame_new[31:24] + frame_new[23:16] +
                    frame_new[15:8];

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    low_d   = low_q;
    bidx_d  = bidx_q;
    frame_d = frame_q;
    res              = '0;
    res.drive_enable = (phase_q == PhHold) || (phase_q == PhStart);
    res.drive_level  = phase_q == PhHold;
    res.busy_res     = phase_q != PhIdle;
    unique case (phase_q)
      PhIdle: begin
        if (in_data_i.start_req) begin
          phase_d = PhHold;
          tick_d  = '0;
          bidx_d  = '0;
          frame_d = '0;
          low_d   = '0;
        end
      end
      PhHold: begin
        tick_d = tick_inc;
        if (tick_inc >= {2'b0, hold_q}) begin
          phase_d = PhStart;
          tick_d  = '0;
        end
      end
      PhStart: begin
        tick_d = tick_inc;
        if (tick_inc >= {6'b0, start_q}) begin
          phase_d = PhWaitLow;
          tick_d  = '0;
        end
      end
      PhWaitLow: begin
        if (changed || tmo) begin
          phase_d = PhHsLow;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhHsLow, PhHsHigh: begin
        if (tmo) begin
          res.result_valid = 1'b1;
          res.status       = StatTimeout;
          phase_d          = PhIdle;
          tick_d           = '0;
        end else if (changed) begin
          phase_d = (phase_q == PhHsLow) ? PhHsHigh : PhDataLow;
          tick_d  = '0;
          bidx_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhDataLow: begin
        if (changed || tmo) begin
          low_d   = wait_dur;
          phase_d = PhDataHigh;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhDataHigh: begin
        if (changed || tmo) begin
          frame_d = frame_new;
          bidx_d  = bidx_new;
          tick_d  = '0;
          if (bidx_new >= BitIdxWidth'(FrameBits)) begin
            res.result_valid = 1'b1;
            if (csum == frame_new[7:0]) begin
              res.humidity = frame_new[39:32];
              res.status   = StatOk;
            end else begin
              res.status = StatChecksum;
            end
            phase_d = PhIdle;
          end else begin
            phase_d = PhDataLow;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      tick_q      <= '0;
      low_q       <= '0;
      bidx_q      <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        low_q   <= low_d;
        bidx_q  <= bidx_d;
        frame_q <= frame_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_enters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PhIdle && in_data_i.start_req |=> phase_q == PhHold)
    else $error("Accepted start request did not enter the hold phase.");

  a_done_means_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_valid |-> phase_q == PhIdle)
    else $error("Finished reading left the reader outside the idle phase.");

  a_bit_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bidx_q <= BitIdxWidth'(FrameBits))
    else $error("Bit index ran past the frame length.");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(phase_q) && $stable(tick_q))
    else $error("Reader state advanced while the output was stalled.");
`endif

endmodule

>>> sim/pulse_width_sensor_reader_test.sv
// Testbench for the pulse width sensor reader: feeds sensor pin waveforms one tick per
// transaction and checks every output transaction against a cycle model kept here or, for
// typed directed rows, their listed expectation. Depends on pwsr_pkg and pulse_width_sensor_reader.
`timescale 1ns / 1ps

module pulse_width_sensor_reader_test;
  import pwsr_pkg::*;

  typedef enum logic {RowItem, RowCfg} row_kind_e;
  typedef enum int {WaitStay, WaitLevelChange, WaitTimedOut} wait_e;

  typedef struct packed {
    row_kind_e               kind;
    logic                    pin;
    logic                    start;
    logic                    typed;
    out_t                    want;
    cfg_idx_e                idx;
    logic [CfgDataWidth-1:0] data;
  } dir_row_t;

  localparam out_t Quiet     = '0;
  localparam out_t DrvHigh   = '{1'b1, 1'b1, 1'b1, 1'b0, 8'd0, StatOk};
  localparam out_t DrvLow    = '{1'b1, 1'b0, 1'b1, 1'b0, 8'd0, StatOk};
  localparam out_t Listening = '{1'b0, 1'b0, 1'b1, 1'b0, 8'd0, StatOk};
  localparam out_t HsTimeout = '{1'b0, 1'b0, 1'b1, 1'b1, 8'd0, StatTimeout};

  localparam int NumDirRows = 26;
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{RowItem, 1'b0, 1'b0, 1'b1, Quiet,     CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b0, 1'b1, Quiet,     CfgHoldHigh, '0},
    '{RowCfg,  1'b0, 1'b0, 1'b0, Quiet,     CfgHoldHigh, '0},
    '{RowCfg,  1'b0, 1'b0, 1'b0, Quiet,     CfgStartLow, '0},
    '{RowCfg,  1'b0, 1'b0, 1'b0, Quiet,     CfgTimeout,  '0},
    '{RowItem, 1'b0, 1'b1, 1'b1, Quiet,     CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b1, 1'b1, DrvHigh,   CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b0, 1'b1, DrvLow,    CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b1, 1'b1, Listening, CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b0, 1'b1, HsTimeout, CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b1, 1'b1, Quiet,     CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b0, 1'b1, DrvHigh,   CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b0, 1'b1, DrvLow,    CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b0, 1'b1, Listening, CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b0, 1'b1, Listening, CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b0, 1'b1, HsTimeout, CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b1, 1'b1, Quiet,     CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b0, 1'b1, DrvHigh,   CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b1, 1'b1, DrvLow,    CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b0, 1'b1, Listening, CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b0, 1'b1, Listening, CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b0, 1'b1, Listening, CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b1, 1'b0, Quiet,     CfgHoldHigh, '0},
    '{RowItem, 1'b0, 1'b0, 1'b0, Quiet,     CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b0, 1'b0, Quiet,     CfgHoldHigh, '0},
    '{RowItem, 1'b1, 1'b1, 1'b0, Quiet,     CfgHoldHigh, '0}
  };

  localparam int NumSegs  = 6;
  localparam int SegItems = 150;
  localparam int SegHold    [NumSegs] = '{3, 0, 1, 2, 5, 1};
  localparam int SegStart   [NumSegs] = '{2, 1, 0, 3, 4, 2};
  localparam int SegTimeout [NumSegs] = '{5, 1, 4194303, 0, 3, 12};
  localparam int SendGap    [3] = '{17, 80, 0};
  localparam int RecvStall  [3] = '{80, 17, 0};
  localparam logic [CfgDataWidth-1:0] HoldMax = CfgDataWidth'((1 << HoldWidth) - 1);

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  logic [HoldWidth-1:0]          hold_cfg;
  logic [StartWidth-1:0]         start_cfg;
  logic [TimeoutWidth-1:0]       timeout_cfg;
  phase_e                        rd_phase;
  logic [TimeoutWidth-1:0]       rd_ticks;
  logic signed [DurWidth-1:0]    rd_low_dur;
  logic [BitIdxWidth-1:0]        rd_bits_n;
  logic [FrameBits-1:0]          rd_frame;

  out_t pending_outputs [$];
  int   n_mismatch = 0;
  int   items_sent = 0;
  int   send_gap_pct = 0;
  int   recv_stall_pct = 0;

  always #1 clk_i = ~clk_i;

  pulse_width_sensor_reader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  function automatic wait_e wait_out(input logic pin, input logic lvl);
    if (pin != lvl) return WaitLevelChange;
    if (rd_ticks >= timeout_cfg) return WaitTimedOut;
    rd_ticks = rd_ticks + 1'b1;
    return WaitStay;
  endfunction

  function automatic out_t next_reader_output(input in_t item);
    out_t                       res;
    wait_e                      w;
    logic signed [DurWidth-1:0] high_dur;
    logic [7:0]                 sum;
    res = '0;
    res.drive_enable = (rd_phase == PhHold) || (rd_phase == PhStart);
    res.drive_level  = (rd_phase == PhHold);
    res.busy_res     = (rd_phase != PhIdle);
    case (rd_phase)
      PhIdle: begin
        if (item.start_req) begin
          rd_phase   = PhHold;
          rd_ticks   = '0;
          rd_bits_n  = '0;
          rd_frame   = '0;
          rd_low_dur = '0;
        end
      end
      PhHold: begin
        rd_ticks = rd_ticks + 1'b1;
        if (rd_ticks >= hold_cfg) begin
          rd_phase = PhStart;
          rd_ticks = '0;
        end
      end
      PhStart: begin
        rd_ticks = rd_ticks + 1'b1;
        if (rd_ticks >= start_cfg) begin
          rd_phase = PhWaitLow;
          rd_ticks = '0;
        end
      end
      PhWaitLow: begin
        if (wait_out(item.pin_level, 1'b1) != WaitStay) begin
          rd_phase = PhHsLow;
          rd_ticks = '0;
        end
      end
      PhHsLow, PhHsHigh: begin
        w = wait_out(item.pin_level, rd_phase == PhHsHigh);
        if (w == WaitTimedOut) begin
          res.result_valid = 1'b1;
          res.status       = StatTimeout;
          rd_phase         = PhIdle;
          rd_ticks         = '0;
        end else if (w == WaitLevelChange) begin
          rd_phase  = (rd_phase == PhHsLow) ? PhHsHigh : PhDataLow;
          rd_ticks  = '0;
          rd_bits_n = '0;
        end
      end
      PhDataLow: begin
        w = wait_out(item.pin_level, 1'b0);
        if (w != WaitStay) begin
          rd_low_dur = (w == WaitTimedOut) ? '1 : {1'b0, rd_ticks};
          rd_phase   = PhDataHigh;
          rd_ticks   = '0;
        end
      end
      PhDataHigh: begin
        w = wait_out(item.pin_level, 1'b1);
        if (w != WaitStay) begin
          high_dur  = (w == WaitTimedOut) ? '1 : {1'b0, rd_ticks};
          rd_frame  = {rd_frame[FrameBits-2:0], high_dur > rd_low_dur};
          rd_bits_n = rd_bits_n + 1'b1;
          rd_ticks  = '0;
          if (rd_bits_n >= FrameBits) begin
            sum = rd_frame[39:32] + rd_frame[31:24] + rd_frame[23:16] + rd_frame[15:8];
            res.result_valid = 1'b1;
            if (sum == rd_frame[7:0]) begin
              res.humidity = rd_frame[39:32];
              res.status   = StatOk;
            end else begin
              res.status = StatChecksum;
            end
            rd_phase = PhIdle;
          end else begin
            rd_phase = PhDataLow;
          end
        end
      end
      default: begin
        rd_phase = PhIdle;
        rd_ticks = '0;
      end
    endcase
    return res;
  endfunction

  task automatic send_tick(input logic pin, input logic start, input logic typed = 1'b0,
                           input out_t want = '0);
    in_t  item;
    out_t predicted;
    item = '{pin_level: pin, start_req: start};
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predicted = next_reader_output(item);
    pending_outputs.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataWidth-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgHoldHigh: hold_cfg    = data[HoldWidth-1:0];
      CfgStartLow: start_cfg   = data[StartWidth-1:0];
      CfgTimeout:  timeout_cfg = data[TimeoutWidth-1:0];
      default: ;
    endcase
  endtask

  // Drives one reading to its end. Each wait phase gets a planned number of ticks at the
  // level being waited out, chosen so that the frame carries the planned bits; a few
  // waits are stretched past the timeout. A noisy reading samples the pin at random.
  task automatic run_reading(input bit noisy);
    logic [FrameBits-1:0] plan;
    phase_e               seen;
    int                   stay, low_plan, cap, tmo;
    logic                 lvl, pin, want_one;
    tmo      = int'(timeout_cfg);
    cap      = (tmo < 3) ? tmo : 3;
    low_plan = 0;
    stay     = 0;
    plan[39:32] = 8'($urandom);
    plan[31:0]  = $urandom;
    if (!noisy && $urandom_range(0, 7) != 0) begin
      plan[7:0] = plan[39:32] + plan[31:24] + plan[23:16] + plan[15:8];
    end
    if (rd_phase == PhIdle) send_tick(1'($urandom), 1'b1);
    seen = PhIdle;
    while (rd_phase != PhIdle) begin
      if (rd_phase != seen) begin
        seen     = rd_phase;
        want_one = plan[FrameBits-1-rd_bits_n];
        stay     = $urandom_range(0, cap);
        case (rd_phase)
          PhWaitLow: stay = $urandom_range(0, 5);
          PhDataLow: begin
            if (want_one) stay = (cap == 0) ? tmo + 1 : $urandom_range(0, cap - 1);
          end
          PhDataHigh: begin
            if (want_one) stay = $urandom_range(low_plan + 1, cap);
            else if (low_plan < 0) stay = tmo + 1;
            else stay = $urandom_range(0, low_plan);
          end
          default: ;
        endcase
        if (tmo <= 64 && rd_phase != PhWaitLow && $urandom_range(0, 39) == 0) stay = tmo + 1;
        if (rd_phase == PhDataLow) low_plan = (stay > tmo) ? -1 : stay;
      end
      lvl = (rd_phase == PhWaitLow) || (rd_phase == PhHsHigh) || (rd_phase == PhDataHigh);
      if (noisy || rd_phase == PhHold || rd_phase == PhStart) begin
        pin = 1'($urandom);
      end else if (stay > 0) begin
        pin = lvl;
        stay--;
      end else begin
        pin = ~lvl;
      end
      send_tick(pin, 1'($urandom));
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected output transaction, expected none, actual %p", $time,
                 out_data);
        n_mismatch++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("drive_enable", want.drive_enable, out_data.drive_enable);
        check_field("drive_level", want.drive_level, out_data.drive_level);
        check_field("busy_res", want.busy_res, out_data.busy_res);
        check_field("result_valid", want.result_valid, out_data.result_valid);
        check_field("humidity", want.humidity, out_data.humidity);
        check_field("status", want.status, out_data.status);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("pulse_width_sensor_reader_test: errors");
    $finish;
  end

  initial begin
    int seg_first;
    hold_cfg       = HoldReset;
    start_cfg      = StartReset;
    timeout_cfg    = TimeoutReset;
    rd_phase       = PhIdle;
    rd_ticks       = '0;
    rd_low_dur     = '0;
    rd_bits_n      = '0;
    rd_frame       = '0;
    send_gap_pct   = SendGap[0];
    recv_stall_pct = RecvStall[0];
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDirRows; r++) begin
      if (DirRows[r].kind == RowCfg) begin
        wait_drained();
        cfg_write(DirRows[r].idx, DirRows[r].data);
      end else begin
        send_tick(DirRows[r].pin, DirRows[r].start, DirRows[r].typed, DirRows[r].want);
      end
    end
    run_reading(1'b0);

    for (int seg = 0; seg < NumSegs; seg++) begin
      wait_drained();
      send_gap_pct   = SendGap[seg / 2];
      recv_stall_pct = RecvStall[seg / 2];
      if (seg == 4) begin
        cfg_write(CfgHoldHigh, HoldMax);
        repeat (6) send_tick(1'($urandom), 1'b0);
        wait_drained();
      end
      cfg_write(CfgHoldHigh, CfgDataWidth'(SegHold[seg]));
      cfg_write(CfgStartLow, CfgDataWidth'(SegStart[seg]));
      cfg_write(CfgTimeout, CfgDataWidth'(SegTimeout[seg]));
      seg_first = items_sent;
      while (items_sent - seg_first < SegItems) begin
        run_reading($urandom_range(0, 5) == 0);
        repeat ($urandom_range(0, 3)) send_tick(1'($urandom), 1'b0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("pulse_width_sensor_reader_test: clean");
    end else begin
      $display("pulse_width_sensor_reader_test: errors");
    end
    $finish;
  end

endmodule
